/* hdl/c2s_pkg.sv */
// Shared definitions for the Cartesian to spherical converter.
// Holds the angle constants, the arctangent table and the lane indexes.
// Depends on nothing; every other file of the block uses it.
package c2s_pkg;

  // Default configuration of the top level.
  localparam int COORD_WIDTH_DEF  = 16;
  localparam int ANGLE_STAGES_DEF = 16;

  // At most this many fraction bits are added to the coordinates.
  localparam int MAX_GUARD = 8;

  // Angle accumulator: 32 bits wrapping, 2^31 is pi.
  localparam int ACC_W   = 32;
  // Output angles: 16 bits, 32768 is pi.
  localparam int ANGLE_W = 16;

  typedef logic [ACC_W-1:0]   acc_t;
  typedef logic [ANGLE_W-1:0] angle_t;

  localparam acc_t ACC_QUARTER       = 32'h4000_0000;
  localparam acc_t ACC_THREE_QUARTER = 32'hC000_0000;
  localparam acc_t ACC_ROUND_HALF    = 32'h0000_8000;

  localparam angle_t HALF_TURN          = 16'd32768;
  localparam angle_t THREE_QUARTER_TURN = 16'd49152;

  // Each cell works on two independent lanes side by side.
  localparam int LANES = 2;
  // Square root lanes.
  localparam int LANE_RAD = 0;
  localparam int LANE_RHO = 1;
  // Rotation lanes.
  localparam int LANE_AZ  = 0;
  localparam int LANE_PO  = 1;

  // atan(2^-i) in accumulator units.
  localparam acc_t ATAN_TABLE [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Table lookup for one rotation step.
  function automatic acc_t atan_unit(input logic [4:0] idx);
    return ATAN_TABLE[idx];
  endfunction

endpackage

/* hdl/c2s_sqrt_cell.sv */
// One cell of the square root chain: it settles one root bit of both lanes.
// Restoring digit-by-digit method, two radicand bits per cell, MSB first.
// Depends on c2s_pkg.
module c2s_sqrt_cell #(
  parameter int ROOT_W = 24,
  parameter int IDX    = 0,
  parameter int PASS_W = 49
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2*ROOT_W-1:0] rad_i  [c2s_pkg::LANES],
  input  logic [ROOT_W-1:0]   root_i [c2s_pkg::LANES],
  input  logic [ROOT_W:0]     rem_i  [c2s_pkg::LANES],
  input  logic [PASS_W-1:0]   pass_i,
  output logic                valid_o,
  output logic [2*ROOT_W-1:0] rad_o  [c2s_pkg::LANES],
  output logic [ROOT_W-1:0]   root_o [c2s_pkg::LANES],
  output logic [ROOT_W:0]     rem_o  [c2s_pkg::LANES],
  output logic [PASS_W-1:0]   pass_o
);

  logic [ROOT_W+2:0] cur   [c2s_pkg::LANES];
  logic [ROOT_W+2:0] trial [c2s_pkg::LANES];
  logic [ROOT_W+2:0] diff  [c2s_pkg::LANES];
  logic [ROOT_W-1:0] root_d [c2s_pkg::LANES];
  logic [ROOT_W:0]   rem_d  [c2s_pkg::LANES];

  // Bring down the next bit pair and try to subtract 4*root + 1.
  always_comb begin
    for (int l = 0; l < c2s_pkg::LANES; l++) begin
      cur[l]   = {rem_i[l], rad_i[l][2*ROOT_W-1-2*IDX -: 2]};
      trial[l] = {1'b0, root_i[l], 2'b01};
      diff[l]  = cur[l] - trial[l];
      if (cur[l] >= trial[l]) begin
        rem_d[l]  = diff[l][ROOT_W:0];
        root_d[l] = {root_i[l][ROOT_W-2:0], 1'b1};
      end else begin
        rem_d[l]  = cur[l][ROOT_W:0];
        root_d[l] = {root_i[l][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Item valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  // Partial results and passenger data move on to the next cell.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= rad_i;
      root_o <= root_d;
      rem_o  <= rem_d;
      pass_o <= pass_i;
    end
  end

endmodule

/* hdl/c2s_cordic_cell.sv */
// One cell of the vectoring rotation chain: one micro-rotation on each lane.
// The rotation direction follows the sign of the second operand.
// Depends on c2s_pkg for the arctangent table.
module c2s_cordic_cell #(
  parameter int AW     = 27,
  parameter int IDX    = 0,
  parameter int PASS_W = 18
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [AW-1:0] a_i   [c2s_pkg::LANES],
  input  logic signed [AW-1:0] b_i   [c2s_pkg::LANES],
  input  c2s_pkg::acc_t        acc_i [c2s_pkg::LANES],
  input  logic [PASS_W-1:0]    pass_i,
  output logic                 valid_o,
  output logic signed [AW-1:0] a_o   [c2s_pkg::LANES],
  output logic signed [AW-1:0] b_o   [c2s_pkg::LANES],
  output c2s_pkg::acc_t        acc_o [c2s_pkg::LANES],
  output logic [PASS_W-1:0]    pass_o
);

  localparam c2s_pkg::acc_t STEP_ANGLE = c2s_pkg::atan_unit(5'(IDX));

  logic signed [AW-1:0] da    [c2s_pkg::LANES];
  logic signed [AW-1:0] db    [c2s_pkg::LANES];
  logic signed [AW-1:0] a_d   [c2s_pkg::LANES];
  logic signed [AW-1:0] b_d   [c2s_pkg::LANES];
  c2s_pkg::acc_t        acc_d [c2s_pkg::LANES];

  // Rotate towards the first axis; arithmetic shifts round to minus infinity.
  always_comb begin
    for (int l = 0; l < c2s_pkg::LANES; l++) begin
      da[l] = b_i[l] >>> IDX;
      db[l] = a_i[l] >>> IDX;
      if (!b_i[l][AW-1]) begin
        a_d[l]   = a_i[l] + da[l];
        b_d[l]   = b_i[l] - db[l];
        acc_d[l] = acc_i[l] + STEP_ANGLE;
      end else begin
        a_d[l]   = a_i[l] - da[l];
        b_d[l]   = b_i[l] + db[l];
        acc_d[l] = acc_i[l] - STEP_ANGLE;
      end
    end
  end

  // Item valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  // Operands, angle and passenger data move on to the next cell.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_o    <= a_d;
      b_o    <= b_d;
      acc_o  <= acc_d;
      pass_o <= pass_i;
    end
  end

endmodule

/* hdl/cartesian_to_spherical.sv */
// Top level of the Cartesian to spherical converter.
// Instantiates the square root cells and the rotation cells; uses c2s_pkg.
//
// Usage:
//   An item on the slave stream carries one point (x, y, z) as signed
//   coordinates. Each item gives exactly one item on the master stream:
//   the rounded radius, the azimuth atan2(y, x) and the polar angle from
//   the positive z axis, both angles in units where 32768 is pi.
//   From acceptance to tvalid an item passes a squaring stage, a summing
//   stage, one square root cell per root bit, an operand preparation
//   stage, one rotation cell per arctangent step and the output register.
//   Throughput is one item per cycle while s_axis_tready is high.
//   A stalled receiver holds the result in the output register; one more
//   item is caught by a skid register, and only when that is full does
//   s_axis_tready fall and every cell hold its contents.
//   During reset no item is taken and the master stream is empty.
module cartesian_to_spherical #(
  parameter int COORD_WIDTH  = c2s_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_STAGES = c2s_pkg::ANGLE_STAGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Slave stream: tdata holds coord_x, coord_y, coord_z from bit 0 up.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // Master stream: tdata holds radius, azimuth, polar_angle from bit 0 up.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [((COORD_WIDTH+2*c2s_pkg::ANGLE_W+7)/8)*8-1:0] m_axis_tdata
);

  localparam int W      = COORD_WIDTH;
  localparam int GUARD  = (32 - W < c2s_pkg::MAX_GUARD) ? 32 - W : c2s_pkg::MAX_GUARD;
  localparam int RW     = W + GUARD;
  localparam int AW     = RW + 3;
  localparam int OUT_DW = ((W + 2*c2s_pkg::ANGLE_W + 7) / 8) * 8;
  localparam int SQ_PW  = 3*W + 1;
  localparam int CD_PW  = W + 2;

  localparam int LA = c2s_pkg::LANE_AZ;
  localparam int LP = c2s_pkg::LANE_PO;
  localparam int LR = c2s_pkg::LANE_RAD;
  localparam int LH = c2s_pkg::LANE_RHO;

  // Flow control.
  logic live_q;
  logic en;
  logic accept;
  logic push;
  logic out_valid_q, skid_valid_q;
  logic [OUT_DW-1:0] out_data_q, skid_data_q, item;

  assign en            = !skid_valid_q;
  assign s_axis_tready = live_q && en;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else begin
      live_q <= 1'b1;
    end
  end

  // Squaring stage.
  logic signed [W-1:0] x_in, y_in, z_in;
  logic [W-1:0]        mx, my, mz;
  logic [2*W-1:0]      mx_w, my_w, mz_w;
  logic                s1_valid_q;
  logic signed [W-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic [2*W-1:0]      s1_sqx_q, s1_sqy_q, s1_sqz_q;

  assign x_in = s_axis_tdata[W-1:0];
  assign y_in = s_axis_tdata[2*W-1:W];
  assign z_in = s_axis_tdata[3*W-1:2*W];
  assign mx   = x_in[W-1] ? W'(-x_in) : W'(x_in);
  assign my   = y_in[W-1] ? W'(-y_in) : W'(y_in);
  assign mz   = z_in[W-1] ? W'(-z_in) : W'(z_in);
  assign mx_w = (2*W)'(mx);
  assign my_w = (2*W)'(my);
  assign mz_w = (2*W)'(mz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x_q   <= x_in;
      s1_y_q   <= y_in;
      s1_z_q   <= z_in;
      s1_sqx_q <= mx_w * mx_w;
      s1_sqy_q <= my_w * my_w;
      s1_sqz_q <= mz_w * mz_w;
    end
  end

  // Summing stage: squared distance in the xy plane and in space.
  logic                s2_valid_q;
  logic signed [W-1:0] s2_x_q, s2_y_q, s2_z_q;
  logic [2*W-1:0]      s2_plane_q, s2_total_q;
  logic [2*W-1:0]      plane_sum;

  assign plane_sum = s1_sqx_q + s1_sqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_x_q     <= s1_x_q;
      s2_y_q     <= s1_y_q;
      s2_z_q     <= s1_z_q;
      s2_plane_q <= plane_sum;
      s2_total_q <= plane_sum + s1_sqz_q;
    end
  end

  // Square root chain: radius lane and scaled planar distance lane.
  logic              sq_valid [RW+1];
  logic [2*RW-1:0]   sq_rad   [RW+1][c2s_pkg::LANES];
  logic [RW-1:0]     sq_root  [RW+1][c2s_pkg::LANES];
  logic [RW:0]       sq_rem   [RW+1][c2s_pkg::LANES];
  logic [SQ_PW-1:0]  sq_pass  [RW+1];

  assign sq_valid[0]     = s2_valid_q;
  assign sq_rad[0][LR]   = (2*RW)'(s2_total_q);
  assign sq_rad[0][LH]   = (2*RW)'(s2_plane_q) << (2*GUARD);
  assign sq_root[0][LR]  = '0;
  assign sq_root[0][LH]  = '0;
  assign sq_rem[0][LR]   = '0;
  assign sq_rem[0][LH]   = '0;
  assign sq_pass[0]      = {(s2_plane_q == '0), s2_z_q, s2_y_q, s2_x_q};

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    c2s_sqrt_cell #(
      .ROOT_W (RW),
      .IDX    (k),
      .PASS_W (SQ_PW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[k]),
      .rad_i   (sq_rad[k]),
      .root_i  (sq_root[k]),
      .rem_i   (sq_rem[k]),
      .pass_i  (sq_pass[k]),
      .valid_o (sq_valid[k+1]),
      .rad_o   (sq_rad[k+1]),
      .root_o  (sq_root[k+1]),
      .rem_o   (sq_rem[k+1]),
      .pass_o  (sq_pass[k+1])
    );
  end

  // Preparation stage: round the radius, scale the operands and turn any
  // vector with a negative first operand by a quarter turn.
  logic signed [W-1:0]  p_x, p_y, p_z;
  logic                 p_plane_zero;
  logic                 round_up;
  logic [W-1:0]         radius;
  logic signed [AW-1:0] x_wide, y_wide, z_wide;
  logic signed [AW-1:0] a0  [c2s_pkg::LANES];
  logic signed [AW-1:0] b0  [c2s_pkg::LANES];
  logic signed [AW-1:0] pa  [c2s_pkg::LANES];
  logic signed [AW-1:0] pb  [c2s_pkg::LANES];
  c2s_pkg::acc_t        pac [c2s_pkg::LANES];

  assign p_x          = sq_pass[RW][W-1:0];
  assign p_y          = sq_pass[RW][2*W-1:W];
  assign p_z          = sq_pass[RW][3*W-1:2*W];
  assign p_plane_zero = sq_pass[RW][3*W];
  assign round_up     = sq_rem[RW][LR] > (RW+1)'(sq_root[RW][LR]);
  assign radius       = sq_root[RW][LR][W-1:0] + W'(round_up);
  assign x_wide       = AW'(p_x);
  assign y_wide       = AW'(p_y);
  assign z_wide       = AW'(p_z);

  always_comb begin
    a0[LA] = x_wide <<< GUARD;
    b0[LA] = y_wide <<< GUARD;
    a0[LP] = z_wide <<< GUARD;
    b0[LP] = signed'(AW'(sq_root[RW][LH]));
    for (int l = 0; l < c2s_pkg::LANES; l++) begin
      if (a0[l][AW-1]) begin
        if (!b0[l][AW-1]) begin
          pa[l]  = b0[l];
          pb[l]  = -a0[l];
          pac[l] = c2s_pkg::ACC_QUARTER;
        end else begin
          pa[l]  = -b0[l];
          pb[l]  = a0[l];
          pac[l] = c2s_pkg::ACC_THREE_QUARTER;
        end
      end else begin
        pa[l]  = a0[l];
        pb[l]  = b0[l];
        pac[l] = '0;
      end
    end
  end

  logic                 pr_valid_q;
  logic signed [AW-1:0] pr_a_q   [c2s_pkg::LANES];
  logic signed [AW-1:0] pr_b_q   [c2s_pkg::LANES];
  c2s_pkg::acc_t        pr_acc_q [c2s_pkg::LANES];
  logic [CD_PW-1:0]     pr_pass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_valid_q <= 1'b0;
    end else if (en) begin
      pr_valid_q <= sq_valid[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_a_q    <= pa;
      pr_b_q    <= pb;
      pr_acc_q  <= pac;
      pr_pass_q <= {p_z[W-1], p_plane_zero, radius};
    end
  end

  // Rotation chain for both angles.
  logic                 cd_valid [ANGLE_STAGES+1];
  logic signed [AW-1:0] cd_a     [ANGLE_STAGES+1][c2s_pkg::LANES];
  logic signed [AW-1:0] cd_b     [ANGLE_STAGES+1][c2s_pkg::LANES];
  c2s_pkg::acc_t        cd_acc   [ANGLE_STAGES+1][c2s_pkg::LANES];
  logic [CD_PW-1:0]     cd_pass  [ANGLE_STAGES+1];

  assign cd_valid[0] = pr_valid_q;
  assign cd_a[0]     = pr_a_q;
  assign cd_b[0]     = pr_b_q;
  assign cd_acc[0]   = pr_acc_q;
  assign cd_pass[0]  = pr_pass_q;

  for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_cordic
    c2s_cordic_cell #(
      .AW     (AW),
      .IDX    (k),
      .PASS_W (CD_PW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cd_valid[k]),
      .a_i     (cd_a[k]),
      .b_i     (cd_b[k]),
      .acc_i   (cd_acc[k]),
      .pass_i  (cd_pass[k]),
      .valid_o (cd_valid[k+1]),
      .a_o     (cd_a[k+1]),
      .b_o     (cd_b[k+1]),
      .acc_o   (cd_acc[k+1]),
      .pass_o  (cd_pass[k+1])
    );
  end

  // Result: round the angles, clamp the polar angle, apply the axis cases.
  c2s_pkg::acc_t  az_sum, po_sum;
  c2s_pkg::angle_t az_round, po_round, azimuth, polar;
  logic           f_plane_zero, f_z_neg;

  assign az_sum       = cd_acc[ANGLE_STAGES][LA] + c2s_pkg::ACC_ROUND_HALF;
  assign po_sum       = cd_acc[ANGLE_STAGES][LP] + c2s_pkg::ACC_ROUND_HALF;
  assign az_round     = az_sum[31:16];
  assign po_round     = po_sum[31:16];
  assign f_plane_zero = cd_pass[ANGLE_STAGES][W];
  assign f_z_neg      = cd_pass[ANGLE_STAGES][W+1];

  always_comb begin
    if (f_plane_zero) begin
      azimuth = '0;
      polar   = f_z_neg ? c2s_pkg::HALF_TURN : '0;
    end else begin
      azimuth = az_round;
      if (po_round > c2s_pkg::HALF_TURN) begin
        polar = (po_round >= c2s_pkg::THREE_QUARTER_TURN) ? '0 : c2s_pkg::HALF_TURN;
      end else begin
        polar = po_round;
      end
    end
  end

  assign item = OUT_DW'({polar, azimuth, cd_pass[ANGLE_STAGES][W-1:0]});
  assign push = en && cd_valid[ANGLE_STAGES];

  // Output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_data_q <= skid_valid_q ? skid_data_q : item;
    end else if (push) begin
      skid_data_q <= item;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* hdl/c2s_chk.sv */
// Port-level checks for the Cartesian to spherical converter.
// Bound to the top level; uses c2s_pkg for the angle constants.
module c2s_chk #(
  parameter int COORD_WIDTH = c2s_pkg::COORD_WIDTH_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((COORD_WIDTH+2*c2s_pkg::ANGLE_W+7)/8)*8-1:0] m_axis_tdata
);

  localparam int W = COORD_WIDTH;

  logic [W-1:0]    radius;
  c2s_pkg::angle_t azimuth, polar;

  assign radius  = m_axis_tdata[W-1:0];
  assign azimuth = m_axis_tdata[W+15:W];
  assign polar   = m_axis_tdata[W+31:W+16];

  // A clock edge seen in reset leaves the master stream empty.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result item shown during reset");

  // A stalled result item holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result item changed");

  // Once out of reset, the input side only stalls while a result item waits.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  // The polar angle never leaves 0 to pi.
  a_polar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> polar <= c2s_pkg::HALF_TURN)
    else $error("polar angle beyond pi");

  // The origin gives zero angles.
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && radius == '0 |-> azimuth == '0 && polar == '0)
    else $error("nonzero angle at the origin");

endmodule

bind cartesian_to_spherical c2s_chk #(
  .COORD_WIDTH (COORD_WIDTH)
) u_c2s_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
